[sv/mf_pkg.sv]
// shared types, constants and compare-exchange functions of the 3x3 median filter
package mf_pkg;

	// line buffer depth and derived widths
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

	// register field widths
	localparam int FW_W   = 11;
	localparam int FH_W   = 16;
	localparam int CC_W   = 3;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// queue between front and back, depth a power of two
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [IDX_W-1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_CHANNELS = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef logic [31:0]      pix_t;
	typedef logic [8:0][7:0]  nine_t;
	typedef logic [8:0][31:0] win_t;

	// one classified word for the back end
	typedef struct packed {
		win_t px;
		logic has_a;
		logic a_med;
		logic has_b;
		logic fend;
	} q_entry_t;

	function automatic nine_t cx(nine_t v, int i, int j);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = (v[i] < v[j]) ? v[i] : v[j];
		hi = (v[i] < v[j]) ? v[j] : v[i];
		v[i] = lo;
		v[j] = hi;
		return v;
	endfunction

	function automatic nine_t kmin(nine_t v, int i, int j);
		if (v[j] < v[i]) v[i] = v[j];
		return v;
	endfunction

	function automatic nine_t kmax(nine_t v, int i, int j);
		if (v[i] > v[j]) v[j] = v[i];
		return v;
	endfunction

	// first three layers: sort each column triple
	function automatic nine_t med_first(nine_t v);
		v = cx(v, 0, 1); v = cx(v, 3, 4); v = cx(v, 6, 7);
		v = cx(v, 1, 2); v = cx(v, 4, 5); v = cx(v, 7, 8);
		v = cx(v, 0, 1); v = cx(v, 3, 4); v = cx(v, 6, 7);
		return v;
	endfunction

	// remaining steps of the network, median lands in slot four
	function automatic logic [7:0] med_last(nine_t v);
		v = kmax(v, 0, 3); v = kmax(v, 3, 6);
		v = cx(v, 1, 4);   v = kmin(v, 4, 7); v = kmax(v, 1, 4);
		v = kmin(v, 5, 8); v = kmin(v, 2, 5);
		v = cx(v, 2, 4);   v = kmin(v, 4, 6); v = kmax(v, 2, 4);
		return v[4];
	endfunction

	// first layers on all four channels
	function automatic win_t win_first(win_t px);
		nine_t v;
		win_t  r;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 9; k++) v[k] = px[k][8*c +: 8];
			v = med_first(v);
			for (int k = 0; k < 9; k++) r[k][8*c +: 8] = v[k];
		end
		return r;
	endfunction

	// last layers on all four channels
	function automatic pix_t win_last(win_t px);
		nine_t v;
		pix_t  r;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 9; k++) v[k] = px[k][8*c +: 8];
			r[8*c +: 8] = med_last(v);
		end
		return r;
	endfunction

endpackage

[sv/mf_if.sv]
// pixel and result channel interfaces
interface mf_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] in_chan0;
	logic [7:0] in_chan1;
	logic [7:0] in_chan2;
	logic [7:0] in_chan3;

	modport source (output valid, op, in_chan0, in_chan1, in_chan2, in_chan3, input ready);
	modport sink (input valid, op, in_chan0, in_chan1, in_chan2, in_chan3, output ready);
endinterface

interface mf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_chan0;
	logic [7:0] out_chan1;
	logic [7:0] out_chan2;
	logic [7:0] out_chan3;
	logic       run_last;
	logic       frame_end;

	modport source (output valid, out_chan0, out_chan1, out_chan2, out_chan3, run_last,
		frame_end, input ready);
	modport sink (input valid, out_chan0, out_chan1, out_chan2, out_chan3, run_last,
		frame_end, output ready);
endinterface

[sv/mf_ram.sv]
// generic single-write, single-read ram with registered read, read-first
module mf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/mf_front.sv]
// front end: registers, frame counters, line buffers, window and classification
module mf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mf_pkg::IDX_W-1:0]      cfg_index,
	input  logic [mf_pkg::CFG_W-1:0]      cfg_data,
	mf_in_if.sink                         pixels,
	input  logic [mf_pkg::QCNT_W-1:0]     q_cnt,
	output logic                          push,
	output mf_pkg::q_entry_t              entry,
	output logic [mf_pkg::CC_W-1:0]       chan_cnt
);

	logic [mf_pkg::FW_W-1:0]   fw_q;
	logic [mf_pkg::FH_W-1:0]   fh_q;
	logic [mf_pkg::CC_W-1:0]   cc_q;
	logic [mf_pkg::CNT_W-1:0]  col_q;
	logic [mf_pkg::FH_W-1:0]   row_q;
	logic                      flush_q;

	logic [mf_pkg::CNT_W-1:0]  w_eff;
	logic [mf_pkg::FH_W:0]     h_eff;
	logic [mf_pkg::ADDR_W-1:0] x;
	logic [mf_pkg::CNT_W-1:0]  x_inc;
	logic [mf_pkg::FH_W:0]     y_inc;
	logic                      wrap;
	logic                      acc;
	logic                      take_px;
	logic                      take_fl;

	logic                      pix_s1;
	logic                      fl_s1;
	logic [mf_pkg::ADDR_W-1:0] x_s1;
	mf_pkg::pix_t              cur_s1;
	logic                      has_a_s1;
	logic                      a_med_s1;
	logic                      has_b_s1;
	logic                      fend_s1;

	mf_pkg::pix_t              old_rd;
	mf_pkg::pix_t              new_rd;
	mf_pkg::pix_t              top;
	mf_pkg::pix_t              mid;
	logic                      byp_q;
	mf_pkg::pix_t              byp_old_q;
	mf_pkg::pix_t              byp_new_q;
	mf_pkg::pix_t              win_q [6];
	logic [mf_pkg::QCNT_W:0]   used;

	// effective frame size and current column
	always_comb begin
		if (fw_q == '0) w_eff = mf_pkg::CNT_W'(1);
		else if (32'(fw_q) > 32'(mf_pkg::MAX_WIDTH)) w_eff = mf_pkg::CNT_W'(mf_pkg::MAX_WIDTH);
		else w_eff = mf_pkg::CNT_W'(fw_q);
		h_eff = (fh_q == '0) ? (mf_pkg::FH_W+1)'(1) : {1'b0, fh_q};
		x     = (col_q >= w_eff) ? '0 : col_q[mf_pkg::ADDR_W-1:0];
		x_inc = mf_pkg::CNT_W'(x) + mf_pkg::CNT_W'(1);
		y_inc = {1'b0, row_q} + (mf_pkg::FH_W+1)'(1);
		wrap  = x_inc >= w_eff;
	end

	// accept while the queue has room for every word in flight
	assign used         = (mf_pkg::QCNT_W+1)'(q_cnt) + (mf_pkg::QCNT_W+1)'(pix_s1 | fl_s1);
	assign pixels.ready = used < (mf_pkg::QCNT_W+1)'(mf_pkg::QDEPTH);
	assign acc          = pixels.valid & pixels.ready;
	assign take_fl      = acc & (pixels.op == mf_pkg::OP_FLUSH) & flush_q;
	assign take_px      = acc & (pixels.op == mf_pkg::OP_PIXEL) & ~flush_q;
	assign chan_cnt     = cc_q;

	// configuration and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= mf_pkg::FW_W'(1);
			fh_q    <= mf_pkg::FH_W'(1);
			cc_q    <= mf_pkg::CC_W'(1);
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mf_pkg::CFG_WIDTH:    fw_q <= cfg_data[mf_pkg::FW_W-1:0];
				mf_pkg::CFG_HEIGHT:   fh_q <= cfg_data[mf_pkg::FH_W-1:0];
				mf_pkg::CFG_CHANNELS: cc_q <= cfg_data[mf_pkg::CC_W-1:0];
				default: ;
			endcase
			if (cfg_index == mf_pkg::CFG_WIDTH || cfg_index == mf_pkg::CFG_HEIGHT ||
				cfg_index == mf_pkg::CFG_CHANNELS) begin
				col_q   <= '0;
				row_q   <= '0;
				flush_q <= 1'b0;
			end
		end else if (take_fl) begin
			if (wrap) begin
				col_q   <= '0;
				row_q   <= '0;
				flush_q <= 1'b0;
			end else begin
				col_q <= x_inc;
			end
		end else if (take_px) begin
			if (wrap) begin
				col_q <= '0;
				if (y_inc >= h_eff) begin
					row_q   <= '0;
					flush_q <= 1'b1;
				end else begin
					row_q <= y_inc[mf_pkg::FH_W-1:0];
				end
			end else begin
				col_q <= x_inc;
			end
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			fl_s1  <= 1'b0;
		end else begin
			pix_s1 <= take_px;
			fl_s1  <= take_fl;
		end
	end

	// stage one payload and result classification
	always_ff @(posedge clk) begin
		x_s1     <= x;
		cur_s1   <= {pixels.in_chan3, pixels.in_chan2, pixels.in_chan1, pixels.in_chan0};
		has_a_s1 <= take_px & (row_q != '0) & (x != '0);
		a_med_s1 <= (row_q != mf_pkg::FH_W'(1)) & (x != mf_pkg::ADDR_W'(1));
		has_b_s1 <= take_fl | ((row_q != '0) & (x_inc == w_eff));
		fend_s1  <= take_fl & wrap;
	end

	// line buffers
	mf_ram #(.WIDTH(32), .DEPTH(mf_pkg::MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (pix_s1),
		.waddr (x_s1),
		.wdata (mid),
		.raddr (x),
		.rdata (old_rd)
	);

	mf_ram #(.WIDTH(32), .DEPTH(mf_pkg::MAX_WIDTH)) u_newer (
		.clk   (clk),
		.we    (pix_s1),
		.waddr (x_s1),
		.wdata (cur_s1),
		.raddr (x),
		.rdata (new_rd)
	);

	// forward a write that hits the column being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) byp_q <= 1'b0;
		else byp_q <= pix_s1 & (x_s1 == x);
	end

	always_ff @(posedge clk) begin
		byp_old_q <= mid;
		byp_new_q <= cur_s1;
	end

	assign top = byp_q ? byp_old_q : old_rd;
	assign mid = byp_q ? byp_new_q : new_rd;

	// two previous columns of the window
	always_ff @(posedge clk) begin
		if (pix_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= cur_s1;
		end
	end

	// word for the back end
	always_comb begin
		for (int k = 0; k < 6; k++) entry.px[k] = win_q[k];
		entry.px[6] = top;
		entry.px[7] = mid;
		entry.px[8] = cur_s1;
		entry.has_a = has_a_s1;
		entry.a_med = a_med_s1;
		entry.has_b = has_b_s1;
		entry.fend  = fend_s1;
	end

	assign push = fl_s1 | (pix_s1 & (has_a_s1 | has_b_s1));

endmodule

[sv/mf_queue.sv]
// short queue of classified words between front and back
module mf_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  mf_pkg::q_entry_t          wr_entry,
	input  logic                      pop,
	output mf_pkg::q_entry_t          head,
	output logic [mf_pkg::QCNT_W-1:0] cnt
);

	mf_pkg::q_entry_t          mem_q [mf_pkg::QDEPTH];
	logic [mf_pkg::QPTR_W-1:0] wr_q;
	logic [mf_pkg::QPTR_W-1:0] rd_q;
	logic [mf_pkg::QCNT_W-1:0] cnt_q;

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + mf_pkg::QPTR_W'(1);
			if (pop) rd_q <= rd_q + mf_pkg::QPTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + mf_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - mf_pkg::QCNT_W'(1);
				default: ;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_entry;
	end

	assign head = mem_q[rd_q];
	assign cnt  = cnt_q;

endmodule

[sv/mf_back.sv]
// back end: median network and result sequencing
module mf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mf_pkg::q_entry_t          head,
	input  logic [mf_pkg::QCNT_W-1:0] q_cnt,
	input  logic [mf_pkg::CC_W-1:0]   chan_cnt,
	output logic                      pop,
	mf_out_if.source                  results
);

	logic         bv_s1;
	mf_pkg::win_t srt_s1;
	mf_pkg::pix_t pass_a_s1;
	mf_pkg::pix_t pass_b_s1;
	logic         has_a_s1;
	logic         a_med_s1;
	logic         has_b_s1;
	logic         fend_s1;
	logic         phase_q;

	logic         out_v_q;
	mf_pkg::pix_t out_pix_q;
	logic         out_last_q;
	logic         out_fend_q;

	mf_pkg::pix_t a_val;
	mf_pkg::pix_t word;
	logic         word_last;
	logic         word_fend;
	logic         out_free;
	logic         emit;
	logic         first_of_two;
	logic         done;
	logic         load;

	// pick the next word from the held entry
	always_comb begin
		a_val        = a_med_s1 ? mf_pkg::win_last(srt_s1) : pass_a_s1;
		out_free     = ~out_v_q | results.ready;
		emit         = bv_s1 & out_free;
		first_of_two = has_a_s1 & ~phase_q & has_b_s1;
		if (has_a_s1 && !phase_q) begin
			word      = a_val;
			word_last = ~has_b_s1;
			word_fend = 1'b0;
		end else begin
			word      = pass_b_s1;
			word_last = 1'b1;
			word_fend = fend_s1;
		end
		done = emit & ~first_of_two;
		load = (q_cnt != '0) & (~bv_s1 | done);
	end

	assign pop = load;

	// entry stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_s1   <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			bv_s1   <= 1'b1;
			phase_q <= 1'b0;
		end else if (done) begin
			bv_s1 <= 1'b0;
		end else if (emit) begin
			phase_q <= 1'b1;
		end
	end

	// entry stage payload, first network layers applied on load
	always_ff @(posedge clk) begin
		if (load) begin
			srt_s1    <= mf_pkg::win_first(head.px);
			pass_a_s1 <= head.px[4];
			pass_b_s1 <= head.px[7];
			has_a_s1  <= head.has_a;
			a_med_s1  <= head.a_med;
			has_b_s1  <= head.has_b;
			fend_s1   <= head.fend;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (out_free) out_v_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_pix_q[7:0]   <= (chan_cnt > mf_pkg::CC_W'(0)) ? word[7:0]   : 8'd0;
			out_pix_q[15:8]  <= (chan_cnt > mf_pkg::CC_W'(1)) ? word[15:8]  : 8'd0;
			out_pix_q[23:16] <= (chan_cnt > mf_pkg::CC_W'(2)) ? word[23:16] : 8'd0;
			out_pix_q[31:24] <= (chan_cnt > mf_pkg::CC_W'(3)) ? word[31:24] : 8'd0;
			out_last_q       <= word_last;
			out_fend_q       <= word_fend;
		end
	end

	assign results.valid     = out_v_q;
	assign results.out_chan0 = out_pix_q[7:0];
	assign results.out_chan1 = out_pix_q[15:8];
	assign results.out_chan2 = out_pix_q[23:16];
	assign results.out_chan3 = out_pix_q[31:24];
	assign results.run_last  = out_last_q;
	assign results.frame_end = out_fend_q;

endmodule

[sv/median_filter_3x3_border_pass.sv]
// 3x3 median filter with border pass-through, up to four 8-bit channels
// a result word is built from the pixel or flush word that completes it, which passes
// stage one (line buffer read), the queue, the back stage and the output register
// throughput: one word per cycle while results.ready holds; row-end pixels give two words
// reset: asynchronous, clears counters, queue and handshakes; line buffers hold garbage
module median_filter_3x3_border_pass (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [mf_pkg::IDX_W-1:0] cfg_index,
	input  logic [mf_pkg::CFG_W-1:0] cfg_data,
	mf_in_if.sink                    pixels,
	mf_out_if.source                 results
);

	logic                      q_push;
	logic                      q_pop;
	mf_pkg::q_entry_t          q_wr;
	mf_pkg::q_entry_t          q_head;
	logic [mf_pkg::QCNT_W-1:0] q_cnt;
	logic [mf_pkg::CC_W-1:0]   chan_cnt;

	// front end
	mf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixels),
		.q_cnt     (q_cnt),
		.push      (q_push),
		.entry     (q_wr),
		.chan_cnt  (chan_cnt)
	);

	// decoupling queue
	mf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.pop      (q_pop),
		.head     (q_head),
		.cnt      (q_cnt)
	);

	// back end
	mf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_cnt    (q_cnt),
		.chan_cnt (chan_cnt),
		.pop      (q_pop),
		.results  (results)
	);

`ifndef SYNTHESIS
	// the front reservation keeps the queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_cnt < mf_pkg::QCNT_W'(mf_pkg::QDEPTH)))
		else $error("queue push while full");

	// back never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_cnt != '0))
		else $error("queue pop while empty");

	// after a word is accepted at the input, the queue count never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready) |=> (q_cnt <= mf_pkg::QCNT_W'(mf_pkg::QDEPTH)))
		else $error("queue count beyond depth");
`endif

endmodule
